### src/dht_pkg.sv
package dht_pkg;

  localparam int MAX_LEN_DEF    = 65536;
  localparam int MAX_TOKENS_DEF = 64;

  localparam int CHAR_W   = 8;
  localparam int CFG_W    = 7;
  localparam int INDEX_W  = 6;
  localparam int START_W  = 16;
  localparam int END_W    = 17;
  localparam int COUNT_W  = 7;
  localparam int DEPTH_W  = 8;

  localparam logic [CFG_W-1:0] MAX_TOKENS_RST = 7'd64;

  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_KEY_OPEN,
    PH_KEY_CLOSE,
    PH_COLON,
    PH_VAL_OPEN,
    PH_VAL_CLOSE,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic               token_valid;
    logic [INDEX_W-1:0] token_index;
    logic [START_W-1:0] token_start;
    logic [END_W-1:0]   token_end;
    logic               is_value;
    logic               done_res;
    logic [COUNT_W-1:0] token_count;
  } res_t;

endpackage

### src/dht_in_reg.sv
module dht_in_reg
  import dht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              advance,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.char_in   <= in_tdata;
      item_r.last_char <= in_tlast;
    end
  end

endmodule

### src/dht_parse.sv
module dht_parse
  import dht_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  item_t            item,
  input  logic [CFG_W-1:0] max_tokens,
  output logic             produce,
  output res_t             res
);

  localparam int POS_W  = $clog2(MAX_LEN);
  localparam int TEND_W = POS_W + 1;
  // wide enough that the count never wraps within one header
  localparam int CNT_W  = (POS_W + 1 > $clog2(MAX_TOKENS + 1)) ? POS_W + 1
                                                               : $clog2(MAX_TOKENS + 1);

  phase_t             phase_r, phase_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [POS_W-1:0]   pstart_r, pstart_nxt;

  logic [CHAR_W-1:0]  c;
  logic               emit, hit, endnow, isval;
  logic [POS_W-1:0]   tstart;
  logic [TEND_W-1:0]  tend;
  logic [DEPTH_W-1:0] d;
  logic [CNT_W-1:0]   limit;

  assign c = item.char_in;

  always_comb begin
    if (9'(max_tokens) > 9'(MAX_TOKENS)) begin
      limit = CNT_W'(MAX_TOKENS);
    end else begin
      limit = CNT_W'(max_tokens);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    pstart_nxt = pstart_r;
    emit       = 1'b0;
    isval      = 1'b0;
    tstart     = '0;
    tend       = '0;
    d          = depth_r;
    hit        = 1'b0;
    endnow     = 1'b0;
    produce    = 1'b0;

    if (phase_r == PH_DRAIN) begin
      if (item.last_char) begin
        phase_nxt  = PH_SEEK;
        depth_nxt  = '0;
        pos_nxt    = '0;
        cnt_nxt    = '0;
        pstart_nxt = '0;
      end
    end else begin
      case (phase_r)
        PH_SEEK: begin
          if (c == CH_LBRACE) phase_nxt = PH_KEY_OPEN;
        end
        PH_KEY_OPEN: begin
          if (c == CH_QUOTE) begin
            pstart_nxt = pos_r;
            phase_nxt  = PH_KEY_CLOSE;
          end
        end
        PH_KEY_CLOSE: begin
          if (c == CH_QUOTE) begin
            emit      = 1'b1;
            tstart    = pstart_r;
            tend      = TEND_W'(pos_r) + TEND_W'(1);
            phase_nxt = PH_COLON;
          end
        end
        PH_COLON: begin
          if (c == CH_COLON) phase_nxt = PH_VAL_OPEN;
        end
        PH_VAL_OPEN: begin
          depth_nxt = '0;
          if (c != CH_SPACE) begin
            if (c == CH_LPAREN) depth_nxt = DEPTH_W'(1);
            pstart_nxt = pos_r;
            phase_nxt  = PH_VAL_CLOSE;
          end
        end
        PH_VAL_CLOSE: begin
          if (c == CH_RPAREN) d = depth_r - DEPTH_W'(1);
          if (c == CH_LPAREN) d = depth_r + DEPTH_W'(1);
          depth_nxt = d;
          if (d == '0 && c == CH_COMMA) begin
            emit      = 1'b1;
            isval     = 1'b1;
            tstart    = pstart_r;
            tend      = TEND_W'(pos_r);
            phase_nxt = PH_KEY_OPEN;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (emit) cnt_nxt = cnt_r + CNT_W'(1);
      pos_nxt = pos_r + POS_W'(1);

      hit     = (phase_nxt != PH_SEEK) && (cnt_nxt == limit);
      endnow  = item.last_char || (pos_r >= POS_W'(MAX_LEN - 1));
      produce = emit || hit || endnow;

      if (endnow) begin
        phase_nxt  = PH_SEEK;
        depth_nxt  = '0;
        pos_nxt    = '0;
        cnt_nxt    = '0;
        pstart_nxt = '0;
      end else if (hit) begin
        phase_nxt = PH_DRAIN;
      end
    end
  end

  always_comb begin
    res             = '0;
    res.token_valid = emit;
    if (emit) begin
      res.token_index = INDEX_W'(cnt_r);
      res.token_start = START_W'(tstart);
      res.token_end   = END_W'(tend);
      res.is_value    = isval;
    end
    res.done_res    = hit || endnow;
    res.token_count = COUNT_W'(emit ? cnt_r + CNT_W'(1) : cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      depth_r  <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      pstart_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      depth_r  <= depth_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      pstart_r <= pstart_nxt;
    end
  end

endmodule

### src/dict_header_tokenizer.sv
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata = char_in, in_tlast = last_char
// out_     out  out_tvalid/out_tready  out_tdata = token fields, out_tuser = flags
// cfg_     in   cfg_valid/cfg_ready    cfg_data = max_tokens
//
// One character per cycle sustained while the output is not stalled; after its input accept
// a result passes the input register, then parse logic into the result register.
// Quiet characters produce no item. Reset (rst_n low, synchronous) restarts
// parsing and sets max_tokens to 64. A stalled result holds the parse stage;
// the input register can still take one character meanwhile if it holds none.
module dict_header_tokenizer
  import dht_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // char_in[7:0]
  input  logic             in_tlast,   // last_char
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // token_index[5:0], token_start[21:6],
                                       // token_end[38:22], token_count[45:39]
  output logic [2:0]       out_tuser,  // token_valid[0], is_value[1], done_res[2]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             item_valid, advance, produce;
  item_t            item;
  res_t             res, res_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] max_tokens_r;

  assign advance   = item_valid && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  dht_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dht_parse #(
    .MAX_LEN    (MAX_LEN),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item),
    .max_tokens (max_tokens_r),
    .produce    (produce),
    .res        (res)
  );

  always_comb begin
    if (advance && produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      max_tokens_r <= MAX_TOKENS_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) max_tokens_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.token_count, res_r.token_end,
                       res_r.token_start, res_r.token_index};
  assign out_tuser  = {res_r.done_res, res_r.is_value, res_r.token_valid};

  a_out_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r.token_valid || res_r.done_res))
    else $error("result item carries neither token nor done");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(res_r.token_count) <= 32'(MAX_TOKENS)))
    else $error("token count above limit");

  a_index_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.token_valid) |->
      (INDEX_W'(res_r.token_index + INDEX_W'(1)) == res_r.token_count[INDEX_W-1:0]))
    else $error("token index and count disagree");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && out_valid_r && !out_tready) |=> item_valid)
    else $error("pending character lost under output stall");

endmodule
